/* hdl/smfa_pkg.sv */
// ----------------------------------------------------------------------------
// smfa_pkg
// Shared types and codes for the sign-magnitude 32.32 fixed-point ALU:
// operation codes, compare codes, operand and beat layouts.
// ----------------------------------------------------------------------------
package smfa_pkg;

    localparam int WHOLE_W = 32;
    localparam int FRAC_W  = 32;
    localparam int MAG_W   = WHOLE_W + FRAC_W;
    localparam int IN_W    = 136;
    localparam int OUT_W   = 72;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_CMP = 2'd3
    } op_t;

    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;
    localparam logic [1:0] ORD_LT = 2'b11;

    typedef struct packed {
        logic               neg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
    } operand_t;

    // input beat, lowest bit first: op, lhs_whole, lhs_frac, lhs_neg,
    // rhs_whole, rhs_frac, rhs_neg, zero fill
    typedef struct packed {
        logic [3:0]         fill;
        logic               rhs_neg;
        logic [FRAC_W-1:0]  rhs_frac;
        logic [WHOLE_W-1:0] rhs_whole;
        logic               lhs_neg;
        logic [FRAC_W-1:0]  lhs_frac;
        logic [WHOLE_W-1:0] lhs_whole;
        op_t                op;
    } in_beat_t;

    // output beat, lowest bit first: res_whole, res_frac, res_neg,
    // ovf_flag, unf_flag, order, zero fill
    typedef struct packed {
        logic [2:0]         fill;
        logic [1:0]         order;
        logic               unf_flag;
        logic               ovf_flag;
        logic               res_neg;
        logic [FRAC_W-1:0]  res_frac;
        logic [WHOLE_W-1:0] res_whole;
    } out_beat_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             ovf;
        logic [1:0]       order;
    } addcmp_res_t;

endpackage

/* hdl/smfa_addcmp.sv */
// ----------------------------------------------------------------------------
// smfa_addcmp
// Sign-magnitude add, subtract and three-way compare of two 32.32 operands.
// Negative zero is taken as positive zero.
// ----------------------------------------------------------------------------
module smfa_addcmp
    import smfa_pkg::*;
(
    input  op_t         op,
    input  operand_t    lhs,
    input  operand_t    rhs,
    output addcmp_res_t res
);

    logic [MAG_W-1:0] lm;
    logic [MAG_W-1:0] rm;
    logic             lz;
    logic             rz;
    logic             ln;
    logic             rn;
    logic             an;
    logic [MAG_W:0]   sum;
    logic [MAG_W:0]   d_lr;
    logic [MAG_W-1:0] d_rl;
    logic             lt;
    logic             eq;

    assign lm   = {lhs.whole, lhs.frac};
    assign rm   = {rhs.whole, rhs.frac};
    assign lz   = (lm == '0);
    assign rz   = (rm == '0);
    assign ln   = lhs.neg & ~lz;
    assign rn   = rhs.neg & ~rz;
    assign an   = (op == OP_SUB) ? (rn ^ ~rz) : rn;
    assign sum  = {1'b0, lm} + {1'b0, rm};
    assign d_lr = {1'b0, lm} - {1'b0, rm};
    assign d_rl = rm - lm;
    assign lt   = d_lr[MAG_W];
    assign eq   = (lm == rm);

    always_comb
    begin
        res = '0;
        if (ln == an)
        begin
            res.mag = sum[MAG_W-1:0];
            res.neg = ln;
            res.ovf = sum[MAG_W];
        end
        else if (eq)
        begin
            res.mag = '0;
            res.neg = 1'b0;
        end
        else if (!lt)
        begin
            res.mag = d_lr[MAG_W-1:0];
            res.neg = ln;
        end
        else
        begin
            res.mag = d_rl;
            res.neg = an;
        end

        if (ln != rn)
        begin
            res.order = ln ? ORD_LT : ORD_GT;
        end
        else if (eq)
        begin
            res.order = ORD_EQ;
        end
        else
        begin
            res.order = (lt ^ ln) ? ORD_LT : ORD_GT;
        end
    end

endmodule

/* hdl/sign_magnitude_fixed_alu.sv */
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_alu
// Sign-magnitude 32.32 fixed-point ALU: add, subtract, multiply, compare.
//
// Input stream s_axis carries one operation per beat: an op code and two
// operands, each a 32-bit integer magnitude, a 32-bit fraction and a sign.
// Output stream m_axis returns one result beat per input beat, in order:
// a 32.32 magnitude with sign, overflow and underflow flags and a signed
// three-way order code (meaningful for compare only).
// The datapath is three register stages: input register, a stage that forms
// the four 32x32 partial products and the add/compare result, and the
// result register that folds the partial products. One beat is taken every
// cycle while m_axis does not stall, the four partial-product multipliers
// setting the stage split. When m_axis stalls, the stages fill up;
// s_axis_tready drops only once all three stages hold a beat. Reset empties
// the pipeline; no beat is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_alu
    import smfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // op, lhs_whole, lhs_frac, lhs_neg, rhs_whole, rhs_frac, rhs_neg, fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // res_whole, res_frac, res_neg, ovf_flag, unf_flag, order, fill
    output logic [OUT_W-1:0] m_axis_tdata
);

    in_beat_t       in_beat;
    in_beat_t       s1_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic           v1_next;
    logic           v2_next;
    logic           v3_next;
    logic           rdy1;
    logic           rdy2;
    logic           rdy3;

    operand_t       lhs;
    operand_t       rhs;
    addcmp_res_t    ac;
    logic           mul_neg;

    op_t            op2_reg;
    addcmp_res_t    ac2_reg;
    logic           mneg2_reg;
    logic [63:0]    t0_reg;
    logic [63:0]    t1_reg;
    logic [63:0]    t2_reg;
    logic [63:0]    t3_reg;

    logic [33:0]    c1;
    logic [34:0]    c2;
    logic [31:0]    c3;
    out_beat_t      out_next;
    out_beat_t      out_reg;

    assign in_beat = in_beat_t'(s_axis_tdata);

    assign rdy3 = ~v3_reg | m_axis_tready;
    assign rdy2 = ~v2_reg | rdy3;
    assign rdy1 = ~v1_reg | rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        v1_next = rdy1 ? s_axis_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: hold the input beat
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= in_beat;
        end
    end

    assign lhs = '{neg: s1_reg.lhs_neg, whole: s1_reg.lhs_whole, frac: s1_reg.lhs_frac};
    assign rhs = '{neg: s1_reg.rhs_neg, whole: s1_reg.rhs_whole, frac: s1_reg.rhs_frac};

    smfa_addcmp u_addcmp (
        .op  (s1_reg.op),
        .lhs (lhs),
        .rhs (rhs),
        .res (ac)
    );

    assign mul_neg = (({lhs.whole, lhs.frac} == '0) || ({rhs.whole, rhs.frac} == '0)) ?
                     1'b0 : (lhs.neg ^ rhs.neg);

    // stage 2: partial products and add/compare result
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            op2_reg   <= s1_reg.op;
            ac2_reg   <= ac;
            mneg2_reg <= mul_neg;
            t0_reg    <= 64'(lhs.frac)  * 64'(rhs.frac);
            t1_reg    <= 64'(lhs.whole) * 64'(rhs.frac);
            t2_reg    <= 64'(lhs.frac)  * 64'(rhs.whole);
            t3_reg    <= 64'(lhs.whole) * 64'(rhs.whole);
        end
    end

    // stage 3: fold partial products, select by op
    always_comb
    begin
        c1 = {2'b00, t0_reg[63:32]} + {2'b00, t1_reg[31:0]} + {2'b00, t2_reg[31:0]};
        c2 = {3'b000, t1_reg[63:32]} + {3'b000, t2_reg[63:32]}
           + {3'b000, t3_reg[31:0]} + {33'd0, c1[33:32]};
        c3 = t3_reg[63:32] + {29'd0, c2[34:32]};

        out_next = '0;
        case (op2_reg)
            OP_ADD, OP_SUB:
            begin
                out_next.res_whole = ac2_reg.mag[MAG_W-1:FRAC_W];
                out_next.res_frac  = ac2_reg.mag[FRAC_W-1:0];
                out_next.res_neg   = ac2_reg.neg;
                out_next.ovf_flag  = ac2_reg.ovf;
            end
            OP_MUL:
            begin
                out_next.res_whole = c2[31:0];
                out_next.res_frac  = c1[31:0];
                out_next.res_neg   = mneg2_reg;
                out_next.ovf_flag  = (c3 != '0);
                out_next.unf_flag  = (t0_reg[31:0] != '0);
            end
            OP_CMP:
            begin
                out_next.order = ac2_reg.order;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            out_reg <= out_next;
        end
    end

    // backpressure only when every stage holds a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free stage");

    // a taken beat lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("taken beat dropped from stage 1");

    // compare results with an unequal order carry no magnitude, sign or flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.order != ORD_EQ) |->
        (out_reg.res_whole == '0 && out_reg.res_frac == '0 && !out_reg.res_neg &&
         !out_reg.ovf_flag && !out_reg.unf_flag))
        else $error("compare result with nonzero payload");

    // an exact zero without flags is positive
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.res_whole == '0 && out_reg.res_frac == '0 &&
         !out_reg.ovf_flag && !out_reg.unf_flag) |-> !out_reg.res_neg)
        else $error("negative zero result");

endmodule

/* test/sign_magnitude_fixed_alu_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_alu_tb
// Drives add, subtract, multiply and compare operations on 32.32
// sign-magnitude operands through the ALU stream ports and checks every
// result beat, field by field and in order, against an independent
// predictor. A directed set covers zero and negative zero, full-scale
// magnitudes, wrap, cancellation and multiply truncation; random traffic
// then runs under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_alu_tb
    import smfa_pkg::*;
();

    class alu_scoreboard;
        out_beat_t   expected_results[$];
        int unsigned ops_seen[4];
        int unsigned results_checked;
        int unsigned failures;

        function out_beat_t fixed_alu_result(in_beat_t b);
            logic [MAG_W-1:0]   lhs_mag;
            logic [MAG_W-1:0]   rhs_mag;
            logic [MAG_W-1:0]   mag;
            logic [MAG_W:0]     sum;
            logic [2*MAG_W-1:0] prod;
            logic               lhs_neg;
            logic               rhs_neg;
            out_beat_t          r;
            r       = '0;
            mag     = '0;
            lhs_mag = {b.lhs_whole, b.lhs_frac};
            rhs_mag = {b.rhs_whole, b.rhs_frac};
            lhs_neg = b.lhs_neg && (lhs_mag != '0);
            rhs_neg = b.rhs_neg && (rhs_mag != '0);
            case (b.op)
                OP_ADD, OP_SUB:
                begin
                    if (b.op == OP_SUB && rhs_mag != '0)
                        rhs_neg = ~rhs_neg;
                    if (lhs_neg == rhs_neg)
                    begin
                        sum        = {1'b0, lhs_mag} + {1'b0, rhs_mag};
                        mag        = sum[MAG_W-1:0];
                        r.ovf_flag = sum[MAG_W];
                        r.res_neg  = lhs_neg;
                    end
                    else if (lhs_mag == rhs_mag)
                    begin
                        mag       = '0;
                        r.res_neg = 1'b0;
                    end
                    else if (lhs_mag > rhs_mag)
                    begin
                        mag       = lhs_mag - rhs_mag;
                        r.res_neg = lhs_neg;
                    end
                    else
                    begin
                        mag       = rhs_mag - lhs_mag;
                        r.res_neg = rhs_neg;
                    end
                end
                OP_MUL:
                begin
                    prod       = {64'b0, lhs_mag} * {64'b0, rhs_mag};
                    mag        = prod[95:32];
                    r.ovf_flag = |prod[127:96];
                    r.unf_flag = |prod[31:0];
                    r.res_neg  = (lhs_mag != '0 && rhs_mag != '0) ? (lhs_neg ^ rhs_neg) : 1'b0;
                end
                OP_CMP:
                begin
                    if (lhs_neg != rhs_neg)
                        r.order = lhs_neg ? ORD_LT : ORD_GT;
                    else if (lhs_mag == rhs_mag)
                        r.order = ORD_EQ;
                    else
                        r.order = ((lhs_mag > rhs_mag) != lhs_neg) ? ORD_GT : ORD_LT;
                end
                default:
                begin
                end
            endcase
            r.res_whole = mag[MAG_W-1:FRAC_W];
            r.res_frac  = mag[FRAC_W-1:0];
            return r;
        endfunction

        function void note_operation(in_beat_t b);
            ops_seen[b.op]++;
            expected_results.push_back(fixed_alu_result(b));
        endfunction

        function int field_diff(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            int        bad;
            results_checked++;
            if (expected_results.size() == 0)
            begin
                failures++;
                $display("%0t: result beat with nothing pending, actual %h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            bad  = 0;
            bad += field_diff("res_whole", 64'(want.res_whole), 64'(got.res_whole));
            bad += field_diff("res_frac", 64'(want.res_frac), 64'(got.res_frac));
            bad += field_diff("res_neg", 64'(want.res_neg), 64'(got.res_neg));
            bad += field_diff("ovf_flag", 64'(want.ovf_flag), 64'(got.ovf_flag));
            bad += field_diff("unf_flag", 64'(want.unf_flag), 64'(got.unf_flag));
            bad += field_diff("order", 64'(want.order), 64'(got.order));
            if (bad != 0)
                failures++;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] HALF     = 32'h8000_0000;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int unsigned   idle_pct  = 0;
    int unsigned   stall_pct = 0;
    alu_scoreboard sb        = new();

    sign_magnitude_fixed_alu i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // note the input beat before checking the output beat of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_operation(in_beat_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(out_beat_t'(m_axis_tdata));
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function in_beat_t make_op(op_t op, logic [31:0] lw, logic [31:0] lf, logic ln,
                               logic [31:0] rw, logic [31:0] rf, logic rn);
        in_beat_t b;
        b           = '0;
        b.op        = op;
        b.lhs_whole = lw;
        b.lhs_frac  = lf;
        b.lhs_neg   = ln;
        b.rhs_whole = rw;
        b.rhs_frac  = rf;
        b.rhs_neg   = rn;
        return b;
    endfunction

    function operand_t random_operand();
        operand_t v;
        v.neg = 1'($urandom_range(1));
        case ($urandom_range(7))
            0:
            begin
                v.whole = '0;
                v.frac  = '0;
            end
            1:
            begin
                v.whole = $urandom_range(3);
                v.frac  = $urandom;
            end
            2:
            begin
                v.whole = '0;
                v.frac  = $urandom_range(255);
            end
            3:
            begin
                v.whole = ALL_ONES;
                v.frac  = ALL_ONES - $urandom_range(1);
            end
            4:
            begin
                v.whole = $urandom >> $urandom_range(31);
                v.frac  = $urandom >> $urandom_range(31);
            end
            default:
            begin
                v.whole = $urandom;
                v.frac  = $urandom;
            end
        endcase
        return v;
    endfunction

    function in_beat_t random_op();
        operand_t lhs;
        operand_t rhs;
        lhs = random_operand();
        rhs = random_operand();
        case ($urandom_range(9))
            0, 1:
            begin
                rhs.whole = lhs.whole;
                rhs.frac  = lhs.frac;
            end
            2:
            begin
                rhs.whole = lhs.whole;
                rhs.frac  = lhs.frac + ($urandom_range(1) ? 32'd1 : ALL_ONES);
            end
            default:
            begin
            end
        endcase
        return make_op(op_t'($urandom_range(3)), lhs.whole, lhs.frac, lhs.neg,
                       rhs.whole, rhs.frac, rhs.neg);
    endfunction

    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // hold off the sender until every pending result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_random(int unsigned count, int unsigned idle, int unsigned stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count)
            send_beat(random_op());
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, negative zero and full scale
        send_beat(make_op(OP_ADD, 0, 0, 1'b0, 0, 0, 1'b0));
        send_beat(make_op(OP_ADD, 0, 0, 1'b1, 0, 0, 1'b1));
        send_beat(make_op(OP_ADD, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES, ALL_ONES, 1'b0));
        send_beat(make_op(OP_ADD, ALL_ONES, ALL_ONES, 1'b1, 0, 1, 1'b1));
        send_beat(make_op(OP_ADD, HALF, 0, 1'b1, HALF, 0, 1'b1));
        // unlike signs: cancellation, either side larger
        send_beat(make_op(OP_ADD, 7, 5, 1'b1, 7, 5, 1'b0));
        send_beat(make_op(OP_ADD, 9, 0, 1'b1, 2, HALF, 1'b0));
        send_beat(make_op(OP_ADD, 1, 0, 1'b1, 3, 1, 1'b0));
        send_beat(make_op(OP_SUB, 12, 34, 1'b0, 12, 34, 1'b0));
        send_beat(make_op(OP_SUB, 5, 0, 1'b0, 0, 0, 1'b1));
        send_beat(make_op(OP_SUB, 0, 0, 1'b1, 0, 0, 1'b1));
        send_beat(make_op(OP_SUB, 4, 1, 1'b1, ALL_ONES, ALL_ONES, 1'b0));
        send_beat(make_op(OP_SUB, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES, ALL_ONES, 1'b1));
        // multiply: zero operand, full scale, unity, truncation to zero
        send_beat(make_op(OP_MUL, 0, 0, 1'b1, 3, 3, 1'b0));
        send_beat(make_op(OP_MUL, 6, 7, 1'b0, 0, 0, 1'b1));
        send_beat(make_op(OP_MUL, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 1'b0));
        send_beat(make_op(OP_MUL, 1, 0, 1'b1, 123, HALF, 1'b1));
        send_beat(make_op(OP_MUL, 0, 1, 1'b1, 0, 1, 1'b0));
        send_beat(make_op(OP_MUL, 3, HALF, 1'b0, 2, 3, 1'b1));
        // compare: equal, signs differ, both negative, negative zero
        send_beat(make_op(OP_CMP, 5, 5, 1'b0, 5, 5, 1'b0));
        send_beat(make_op(OP_CMP, 1, 0, 1'b1, 0, 1, 1'b0));
        send_beat(make_op(OP_CMP, 2, 0, 1'b1, 3, 0, 1'b1));
        send_beat(make_op(OP_CMP, 0, 0, 1'b1, 0, 0, 1'b0));
        send_beat(make_op(OP_CMP, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES, ALL_ONES - 1, 1'b0));
        send_beat(make_op(OP_CMP, 0, 0, 1'b0, 0, 1, 1'b1));
        drain();

        run_random(375, 0, 0);
        run_random(375, 50, 0);
        run_random(375, 0, 50);
        run_random(375, 8, 8);

        repeat (10) @(posedge clk);

        $display("tb: ran %0d add, %0d subtract, %0d multiply, %0d compare operations",
                 sb.ops_seen[OP_ADD], sb.ops_seen[OP_SUB], sb.ops_seen[OP_MUL],
                 sb.ops_seen[OP_CMP]);
        $display("tb: %0d result beats checked across four sender/receiver idle mixes",
                 sb.results_checked);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/smfa_pkg.sv
hdl/smfa_addcmp.sv
hdl/sign_magnitude_fixed_alu.sv
test/sign_magnitude_fixed_alu_tb.sv
